[hdl/vccc_pkg.sv]
// Package for the vending credit and change controller.
// Holds request and status codes, coin values and the reset contents of the tables.
// Depends on nothing.
package vccc_pkg;

    localparam int NUM_ITEMS = 9;
    localparam int SLOTS = 16;
    localparam int NUM_COINS = 5;

    localparam logic [8:0] CREDIT_MAX = 9'd511;
    localparam logic [15:0] STORE_MAX = 16'hFFFF;
    localparam logic [5:0] MAX_CHANGE = 6'd40;
    localparam logic [7:0] STOCK_RESET = 8'd9;

    typedef enum logic [1:0] {
        OP_SELECT = 2'd0,
        OP_COIN = 2'd1,
        OP_PRICE = 2'd2,
        OP_STOCK = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_SELECTED = 3'd0,
        ST_CREDIT = 3'd1,
        ST_DISPENSED = 3'd2,
        ST_BAD_ITEM = 3'd3,
        ST_NO_STOCK = 3'd4,
        ST_BAD_COIN = 3'd5,
        ST_WRONG_MODE = 3'd6,
        ST_WRITTEN = 3'd7
    } status_t;

    localparam logic [2:0] COIN_NICKEL = 3'd0;
    localparam logic [2:0] COIN_DIME = 3'd1;
    localparam logic [2:0] COIN_QUARTER = 3'd2;
    localparam logic [2:0] COIN_LOONIE = 3'd3;
    localparam logic [2:0] COIN_TOONIE = 3'd4;

    localparam logic [7:0] PRICE_RESET [SLOTS] = '{
        8'd40, 8'd60, 8'd50, 8'd30, 8'd40, 8'd80, 8'd55, 8'd45,
        8'd60, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    localparam logic [15:0] STORE_RESET [NUM_COINS] = '{
        16'd10, 16'd10, 16'd10, 16'd10, 16'd0
    };

    // Value of a coin in 5-cent units; invalid codes are worth nothing.
    function automatic logic [5:0] coin_units(input logic [2:0] code);
        logic [5:0] units;
        case (code)
            COIN_NICKEL: units = 6'd1;
            COIN_DIME: units = 6'd2;
            COIN_QUARTER: units = 6'd5;
            COIN_LOONIE: units = 6'd20;
            COIN_TOONIE: units = 6'd40;
            default: units = 6'd0;
        endcase
        return units;
    endfunction

endpackage

[hdl/vending_credit_and_change_controller.sv]
// Vending credit and change controller, top level.
// Depends on vccc_pkg for codes, coin values and table reset contents.
//
// The controller takes one request per clock cycle while the output side is not
// stalled, and returns one result per request. A request is first held in an input
// register; once the output register can take a result, the price and stock tables,
// the credit and the coin counts are read and updated in one step and the result is
// loaded into the output register, so consecutive requests see each other's effects
// in order. Money is counted in 5-cent units and change is paid greedily in loonies,
// quarters, dimes and nickels.
module vending_credit_and_change_controller (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [3:0] item,
    input  logic [2:0] coin,
    input  logic [7:0] new_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [8:0] credit,
    output logic       change_loonies,
    output logic [1:0] change_quarters,
    output logic [1:0] change_dimes,
    output logic       change_nickels,
    output logic [7:0] stock_left
);
    import vccc_pkg::*;

    logic        req_valid_reg;
    op_t         op_reg;
    logic [3:0]  item_reg;
    logic [2:0]  coin_reg;
    logic [7:0]  value_reg;

    logic        paying_reg, paying_next;
    logic [3:0]  slot_reg, slot_next;
    logic [8:0]  credit_reg, credit_next;
    logic [7:0]  price_reg [SLOTS];
    logic [7:0]  price_next [SLOTS];
    logic [7:0]  stock_reg [SLOTS];
    logic [7:0]  stock_next [SLOTS];
    logic [15:0] store_reg [NUM_COINS];
    logic [15:0] store_next [NUM_COINS];
    logic [31:0] earned_reg, earned_next;

    logic        res_valid_reg;
    status_t     status_reg, status_next;
    logic [8:0]  res_credit_reg, res_credit_next;
    logic        loonies_reg, loonies_next;
    logic [1:0]  quarters_reg, quarters_next;
    logic [1:0]  dimes_reg, dimes_next;
    logic        nickels_reg, nickels_next;
    logic [7:0]  stock_left_reg, stock_left_next;

    logic        advance;
    logic        item_ok;
    logic [3:0]  rd_slot;
    logic [7:0]  price_rd;
    logic [7:0]  stock_rd;
    logic [7:0]  stock_dec;
    logic [5:0]  coin_val;
    logic [9:0]  sum_raw;
    logic [8:0]  sum;
    logic        reaches;
    logic [8:0]  rem_wide;
    logic        too_much;
    logic [5:0]  rem;
    logic        chg_l;
    logic [4:0]  rem1;
    logic [1:0]  chg_q;
    logic [4:0]  rem2;
    logic [1:0]  chg_d;
    logic        chg_n;
    logic [1:0]  take [NUM_COINS];
    logic [15:0] cnt;
    logic [32:0] earned_sum;

    assign advance = req_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg <= op_t'(op);
            item_reg <= item;
            coin_reg <= coin;
            value_reg <= new_value;
        end
    end

    // Shared arithmetic for all requests: item check and table reads, and the sums and change for a coin request.
    always_comb
    begin
        item_ok = {28'd0, item_reg} < NUM_ITEMS;
        rd_slot = (op_reg == OP_COIN) ? slot_reg : item_reg;
        price_rd = price_reg[slot_reg];
        stock_rd = stock_reg[rd_slot];
        stock_dec = (stock_rd != 8'd0) ? stock_rd - 8'd1 : 8'd0;
        coin_val = coin_units(coin_reg);
        sum_raw = {1'b0, credit_reg} + {4'd0, coin_val};
        sum = (sum_raw > {1'b0, CREDIT_MAX}) ? CREDIT_MAX : sum_raw[8:0];
        reaches = sum >= {1'b0, price_rd};
        rem_wide = sum - {1'b0, price_rd};
        too_much = reaches && (rem_wide >= {3'd0, MAX_CHANGE});
        rem = rem_wide[5:0];
        chg_l = rem >= 6'd20;
        rem1 = chg_l ? 5'(rem - 6'd20) : rem[4:0];
        if (rem1 >= 5'd15)
        begin
            chg_q = 2'd3;
        end
        else if (rem1 >= 5'd10)
        begin
            chg_q = 2'd2;
        end
        else if (rem1 >= 5'd5)
        begin
            chg_q = 2'd1;
        end
        else
        begin
            chg_q = 2'd0;
        end
        rem2 = rem1 - {1'b0, chg_q, 2'b00} - {3'd0, chg_q};
        chg_d = rem2[2:1];
        chg_n = rem2[0];
        earned_sum = {1'b0, earned_reg} + {27'd0, coin_val};
    end

    always_comb
    begin
        paying_next = paying_reg;
        slot_next = slot_reg;
        credit_next = credit_reg;
        price_next = price_reg;
        stock_next = stock_reg;
        store_next = store_reg;
        earned_next = earned_reg;
        status_next = ST_WRONG_MODE;
        res_credit_next = credit_reg;
        loonies_next = 1'b0;
        quarters_next = 2'd0;
        dimes_next = 2'd0;
        nickels_next = 1'b0;
        stock_left_next = 8'd0;
        for (int k = 0; k < NUM_COINS; k++)
        begin
            take[k] = 2'd0;
        end
        cnt = 16'd0;

        case (op_reg)
            OP_COIN:
            begin
                stock_left_next = stock_rd;
                if (!paying_reg)
                begin
                    status_next = ST_WRONG_MODE;
                end
                else if (coin_reg > COIN_TOONIE || too_much)
                begin
                    status_next = ST_BAD_COIN;
                end
                else
                begin
                    credit_next = sum;
                    res_credit_next = sum;
                    earned_next = earned_sum[32] ? 32'hFFFF_FFFF : earned_sum[31:0];
                    status_next = ST_CREDIT;
                    if (reaches)
                    begin
                        status_next = ST_DISPENSED;
                        loonies_next = chg_l;
                        quarters_next = chg_q;
                        dimes_next = chg_d;
                        nickels_next = chg_n;
                        take[COIN_LOONIE] = {1'b0, chg_l};
                        take[COIN_QUARTER] = chg_q;
                        take[COIN_DIME] = chg_d;
                        take[COIN_NICKEL] = {1'b0, chg_n};
                        stock_next[slot_reg] = stock_dec;
                        stock_left_next = stock_dec;
                        credit_next = 9'd0;
                        paying_next = 1'b0;
                    end
                    for (int k = 0; k < NUM_COINS; k++)
                    begin
                        cnt = store_reg[k];
                        if (coin_reg == 3'(k) && cnt != STORE_MAX)
                        begin
                            cnt = cnt + 16'd1;
                        end
                        store_next[k] = (cnt > {14'd0, take[k]}) ? cnt - {14'd0, take[k]} : 16'd0;
                    end
                end
            end
            default:
            begin
                stock_left_next = item_ok ? stock_rd : 8'd0;
                if (paying_reg)
                begin
                    status_next = ST_WRONG_MODE;
                end
                else if (!item_ok)
                begin
                    status_next = ST_BAD_ITEM;
                end
                else if (op_reg == OP_SELECT)
                begin
                    if (stock_rd == 8'd0)
                    begin
                        status_next = ST_NO_STOCK;
                    end
                    else
                    begin
                        status_next = ST_SELECTED;
                        slot_next = item_reg;
                        credit_next = 9'd0;
                        res_credit_next = 9'd0;
                        paying_next = 1'b1;
                    end
                end
                else
                begin
                    status_next = ST_WRITTEN;
                    if (op_reg == OP_PRICE)
                    begin
                        price_next[item_reg] = value_reg;
                    end
                    else
                    begin
                        stock_next[item_reg] = value_reg;
                        stock_left_next = value_reg;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paying_reg <= 1'b0;
            slot_reg <= 4'd0;
            credit_reg <= 9'd0;
            earned_reg <= 32'd0;
            for (int i = 0; i < SLOTS; i++)
            begin
                price_reg[i] <= PRICE_RESET[i];
                stock_reg[i] <= STOCK_RESET;
            end
            for (int k = 0; k < NUM_COINS; k++)
            begin
                store_reg[k] <= STORE_RESET[k];
            end
        end
        else if (advance)
        begin
            paying_reg <= paying_next;
            slot_reg <= slot_next;
            credit_reg <= credit_next;
            earned_reg <= earned_next;
            price_reg <= price_next;
            stock_reg <= stock_next;
            store_reg <= store_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
            res_credit_reg <= res_credit_next;
            loonies_reg <= loonies_next;
            quarters_reg <= quarters_next;
            dimes_reg <= dimes_next;
            nickels_reg <= nickels_next;
            stock_left_reg <= stock_left_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign status = status_reg;
    assign credit = res_credit_reg;
    assign change_loonies = loonies_reg;
    assign change_quarters = quarters_reg;
    assign change_dimes = dimes_reg;
    assign change_nickels = nickels_reg;
    assign stock_left = stock_left_reg;

endmodule

[sim/testbench.sv]
// Self-checking testbench for vending_credit_and_change_controller.
// Sends directed and random purchase requests and checks every result against a local
// predictor. Depends on vccc_pkg and the controller RTL.
`timescale 1ns / 100ps

module testbench;
    import vccc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [2:0] COIN_INVALID_FIRST = 3'd5;
    localparam logic [2:0] COIN_INVALID_LAST = 3'd7;

    typedef struct packed {
        status_t    status;
        logic [8:0] credit;
        logic       loonies;
        logic [1:0] quarters;
        logic [1:0] dimes;
        logic       nickels;
        logic [7:0] stock;
    } vend_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] op;
    logic [3:0] item;
    logic [2:0] coin;
    logic [7:0] new_value;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] status;
    logic [8:0] credit;
    logic       change_loonies;
    logic [1:0] change_quarters;
    logic [1:0] change_dimes;
    logic       change_nickels;
    logic [7:0] stock_left;

    bit           busy_paying;
    logic [3:0]   chosen_item;
    int           credit_held;
    int           item_price [16];
    int           item_stock [16];
    vend_result_t pending_results [$];
    bit           no_idle;
    int           requests_sent;
    int           mismatch_count;
    int           stalled_cycles;

    vending_credit_and_change_controller uut (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int coin_value(input logic [2:0] c);
        case (c)
            COIN_NICKEL: return 1;
            COIN_DIME: return 2;
            COIN_QUARTER: return 5;
            COIN_LOONIE: return 20;
            COIN_TOONIE: return 40;
            default: return 0;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 24);
    endfunction

    // Applies one request to the local machine state and returns the result it should give.
    function automatic vend_result_t predict_vend(input op_t o, input logic [3:0] it,
                                                  input logic [2:0] c, input logic [7:0] v);
        vend_result_t r;
        int sum;
        int rem;
        int price;
        logic [3:0] slot;
        bit item_ok;
        r = '0;
        item_ok = it < NUM_ITEMS;
        if (o == OP_COIN)
        begin
            slot = chosen_item;
            price = item_price[slot];
            if (!busy_paying)
                r.status = ST_WRONG_MODE;
            else if (c > COIN_TOONIE)
                r.status = ST_BAD_COIN;
            else
            begin
                sum = credit_held + coin_value(c);
                if (sum > 511)
                    sum = 511;
                if (sum >= price && sum - price >= 40)
                    r.status = ST_BAD_COIN;
                else if (sum >= price)
                begin
                    rem = sum - price;
                    r.loonies = 1'(rem / 20);
                    rem = rem % 20;
                    r.quarters = 2'(rem / 5);
                    rem = rem % 5;
                    r.dimes = 2'(rem / 2);
                    r.nickels = 1'(rem % 2);
                    if (item_stock[slot] > 0)
                        item_stock[slot]--;
                    r.status = ST_DISPENSED;
                    r.credit = 9'(sum);
                    credit_held = 0;
                    busy_paying = 1'b0;
                end
                else
                begin
                    credit_held = sum;
                    r.status = ST_CREDIT;
                end
            end
            if (r.status != ST_DISPENSED)
                r.credit = 9'(credit_held);
            r.stock = 8'(item_stock[slot]);
        end
        else
        begin
            if (busy_paying)
                r.status = ST_WRONG_MODE;
            else if (!item_ok)
                r.status = ST_BAD_ITEM;
            else if (o == OP_SELECT)
            begin
                if (item_stock[it] == 0)
                    r.status = ST_NO_STOCK;
                else
                begin
                    chosen_item = it;
                    credit_held = 0;
                    busy_paying = 1'b1;
                    r.status = ST_SELECTED;
                end
            end
            else
            begin
                if (o == OP_PRICE)
                    item_price[it] = int'(v);
                else
                    item_stock[it] = int'(v);
                r.status = ST_WRITTEN;
            end
            r.credit = 9'(credit_held);
            r.stock = item_ok ? 8'(item_stock[it]) : 8'd0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(input op_t o, input logic [3:0] it, input logic [2:0] c,
                                input logic [7:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        op <= o;
        item <= it;
        coin <= c;
        new_value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_vend(o, it, c, v));
        requests_sent++;
    endtask

    task automatic send_noise();
        send_request(op_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                     3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    endtask

    task automatic run_purchases(input int count);
        int target;
        int r;
        int guard;
        logic [3:0] slot;
        logic [7:0] v;
        target = requests_sent + count;
        while (requests_sent < target)
        begin
            r = $urandom_range(0, 99);
            slot = 4'($urandom_range(0, NUM_ITEMS - 1));
            if (r < 15)
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    v = 8'($urandom_range(0, 10));
                else if (r < 90)
                    v = 8'($urandom_range(10, 100));
                else
                    v = 8'($urandom_range(100, 255));
                send_request(OP_PRICE, slot, 3'($urandom_range(0, 7)), v);
            end
            else if (r < 30)
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    v = 8'd0;
                else if (r < 85)
                    v = 8'($urandom_range(1, 20));
                else
                    v = 8'($urandom_range(0, 255));
                send_request(OP_STOCK, slot, 3'($urandom_range(0, 7)), v);
            end
            else if (r < 38)
                send_noise();
            else
            begin
                send_request(OP_SELECT, slot, 3'($urandom_range(0, 7)),
                             8'($urandom_range(0, 255)));
                guard = 0;
                while (busy_paying && guard < 200)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_noise();
                    else
                        send_request(OP_COIN, 4'($urandom_range(0, 15)),
                                     3'($urandom_range(COIN_NICKEL, COIN_TOONIE)),
                                     8'($urandom_range(0, 255)));
                    guard++;
                end
            end
        end
    endtask

    task automatic test_directed();
        send_request(OP_COIN, 4'($urandom_range(0, 15)), COIN_NICKEL,
                     8'($urandom_range(0, 255)));
        send_request(OP_SELECT, 4'd9, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        send_request(OP_SELECT, 4'd15, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        send_request(OP_PRICE, 4'd15, 3'($urandom_range(0, 7)), 8'd255);
        send_request(OP_STOCK, 4'd0, 3'($urandom_range(0, 7)), 8'd0);
        send_request(OP_SELECT, 4'd0, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        send_request(OP_STOCK, 4'd0, 3'($urandom_range(0, 7)), 8'd255);
        send_request(OP_PRICE, 4'd8, 3'($urandom_range(0, 7)), 8'd0);
        send_request(OP_SELECT, 4'd8, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        send_request(OP_COIN, 4'($urandom_range(0, 15)), COIN_TOONIE,
                     8'($urandom_range(0, 255)));
        send_request(OP_COIN, 4'($urandom_range(0, 15)), COIN_INVALID_LAST,
                     8'($urandom_range(0, 255)));
        send_request(OP_COIN, 4'($urandom_range(0, 15)), COIN_INVALID_FIRST,
                     8'($urandom_range(0, 255)));
        send_request(OP_SELECT, 4'd1, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        send_request(OP_PRICE, 4'd1, 3'($urandom_range(0, 7)), 8'd10);
        send_request(OP_COIN, 4'($urandom_range(0, 15)), COIN_LOONIE,
                     8'($urandom_range(0, 255)));
        send_request(OP_PRICE, 4'd2, 3'($urandom_range(0, 7)), 8'd255);
        send_request(OP_SELECT, 4'd2, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        repeat (7)
            send_request(OP_COIN, 4'($urandom_range(0, 15)), COIN_TOONIE,
                         8'($urandom_range(0, 255)));
        send_request(OP_PRICE, 4'd3, 3'($urandom_range(0, 7)), 8'd1);
        send_request(OP_SELECT, 4'd3, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        send_request(OP_COIN, 4'($urandom_range(0, 15)), COIN_LOONIE,
                     8'($urandom_range(0, 255)));
        send_request(OP_SELECT, 4'd4, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        send_request(OP_COIN, 4'($urandom_range(0, 15)), COIN_DIME,
                     8'($urandom_range(0, 255)));
        send_request(OP_COIN, 4'($urandom_range(0, 15)), COIN_QUARTER,
                     8'($urandom_range(0, 255)));
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        run_purchases(200);
        no_idle = 1'b0;
    endtask

    task automatic test_random_purchases();
        run_purchases(1800);
    endtask

    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = pick_gap();
            if (gap == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_checker
        vend_result_t want;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with no request pending", status, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (credit !== want.credit)
                        report_mismatch("credit", credit, want.credit);
                    if (change_loonies !== want.loonies)
                        report_mismatch("change_loonies", change_loonies, want.loonies);
                    if (change_quarters !== want.quarters)
                        report_mismatch("change_quarters", change_quarters, want.quarters);
                    if (change_dimes !== want.dimes)
                        report_mismatch("change_dimes", change_dimes, want.dimes);
                    if (change_nickels !== want.nickels)
                        report_mismatch("change_nickels", change_nickels, want.nickels);
                    if (stock_left !== want.stock)
                        report_mismatch("stock_left", stock_left, want.stock);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_SELECT;
        item = 4'd0;
        coin = COIN_NICKEL;
        new_value = 8'd0;
        no_idle = 1'b0;
        requests_sent = 0;
        mismatch_count = 0;
        stalled_cycles = 0;
        busy_paying = 1'b0;
        chosen_item = 4'd0;
        credit_held = 0;
        item_price = '{40, 60, 50, 30, 40, 80, 55, 45, 60, 0, 0, 0, 0, 0, 0, 0};
        foreach (item_stock[i])
            item_stock[i] = 9;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_back_to_back();
        test_random_purchases();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
